/* sv/rdmc_pkg.sv */
// Shared types and codes of the randomized depth-first maze carver.
// Used by rdmc_ctrl, rdmc_dpath and random_dfs_maze_carver; depends on nothing.
`default_nettype none

package rdmc_pkg;

  localparam int CFG_W = 6;
  localparam int CNT_W = 2 * CFG_W;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  // input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;

  // result action codes
  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_CARVED  = 3'd1;
  localparam logic [2:0] ACT_BACK    = 3'd2;
  localparam logic [2:0] ACT_ALREADY = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  // neighbor scan slots
  localparam logic [2:0] SCAN_CUR   = 3'd0;
  localparam logic [2:0] SCAN_UP    = 3'd1;
  localparam logic [2:0] SCAN_DOWN  = 3'd2;
  localparam logic [2:0] SCAN_LEFT  = 3'd3;
  localparam logic [2:0] SCAN_RIGHT = 3'd4;

  typedef struct packed {
    logic       latch;
    logic       init;
    logic       sweep;
    logic       scan_rd;
    logic [2:0] scan_sel;
    logic       decide;
    logic       wr_cur;
    logic       wr_nb;
    logic       pop_rd;
    logic       pop_ld;
    logic       query_rd;
    logic       load_out;
    logic [2:0] act;
  } cmd_t;

  typedef struct packed {
    logic complete;
    logic has_nb;
    logic sweep_last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

/* sv/rdmc_ctrl.sv */
// Sequencing state machine of the maze carver: steps each item through the
// datapath by command bits. Depends on rdmc_pkg.
`default_nettype none

module rdmc_ctrl import rdmc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] func,
  output logic            in_ready,
  output cmd_t            cmd,
  input  wire stat_t      stat
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SWEEP    = 4'd1;
  localparam logic [3:0] S_STEP     = 4'd2;
  localparam logic [3:0] S_CAP      = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_APPLY    = 4'd5;
  localparam logic [3:0] S_WR_NB    = 4'd6;
  localparam logic [3:0] S_POP_WAIT = 4'd7;
  localparam logic [3:0] S_QUERY    = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0] state, state_next;
  logic [2:0] scan_k, scan_k_next;
  logic [2:0] act_q, act_q_next;
  logic       reply, reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_SWEEP;
      scan_k <= SCAN_CUR;
      act_q  <= ACT_START;
      reply  <= 1'b0;
    end else begin
      state  <= state_next;
      scan_k <= scan_k_next;
      act_q  <= act_q_next;
      reply  <= reply_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    scan_k_next = scan_k;
    act_q_next  = act_q;
    reply_next  = reply;
    cmd         = '0;
    cmd.scan_sel = scan_k;
    cmd.act      = act_q;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          priority if (func == FUNC_START) begin
            cmd.init   = 1'b1;
            reply_next = 1'b1;
            act_q_next = ACT_START;
            state_next = S_SWEEP;
          end else if (func == FUNC_STEP) begin
            scan_k_next = SCAN_CUR;
            state_next  = S_STEP;
          end else begin
            state_next = S_QUERY;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          reply_next = 1'b0;
          state_next = reply ? S_FIN : S_IDLE;
        end
      end
      S_STEP: begin
        if (scan_k == SCAN_CUR && stat.complete) begin
          act_q_next = ACT_ALREADY;
          state_next = S_FIN;
        end else begin
          cmd.scan_rd = 1'b1;
          if (scan_k == SCAN_RIGHT) begin
            state_next = S_CAP;
          end else begin
            scan_k_next = scan_k + 3'd1;
          end
        end
      end
      S_CAP: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (stat.has_nb) begin
          cmd.wr_cur = 1'b1;
          state_next = S_WR_NB;
        end else begin
          cmd.pop_rd = 1'b1;
          state_next = S_POP_WAIT;
        end
      end
      S_WR_NB: begin
        cmd.wr_nb  = 1'b1;
        act_q_next = ACT_CARVED;
        state_next = S_FIN;
      end
      S_POP_WAIT: begin
        cmd.pop_ld = 1'b1;
        act_q_next = ACT_BACK;
        state_next = S_FIN;
      end
      S_QUERY: begin
        cmd.query_rd = 1'b1;
        act_q_next   = ACT_READ;
        state_next   = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register is free
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/rdmc_dpath.sv */
// Datapath of the maze carver: cell memory (visited bit and walls), path stack,
// walk registers and the output register. Depends on rdmc_pkg.
`default_nettype none

module rdmc_dpath import rdmc_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output stat_t                 stat,
  input  wire logic [CFG_W-1:0] grid_rows,
  input  wire logic [CFG_W-1:0] grid_cols,
  input  wire logic [7:0]       rand_value,
  input  wire logic [4:0]       query_x,
  input  wire logic [4:0]       query_y,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [2:0]            action,
  output logic [1:0]            carve_dir,
  output logic [4:0]            cell_x,
  output logic [4:0]            cell_y,
  output logic                  wall_up,
  output logic                  wall_down,
  output logic                  wall_left,
  output logic                  wall_right,
  output logic                  complete
);

  localparam int XW    = $clog2(MAX_ROWS);
  localparam int YW    = $clog2(MAX_COLS);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = AW + 1;
  localparam logic [SW-1:0] CELLS    = SW'(MAX_ROWS * MAX_COLS);
  localparam logic [8:0]    ROWS_LIM = 9'(MAX_ROWS);
  localparam logic [8:0]    COLS_LIM = 9'(MAX_COLS);

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [8:0] lim);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (9'(v) > lim) r = lim[CFG_W-1:0];
    else r = v;
    return r;
  endfunction

  // memories
  logic [4:0]    cell_mem [DEPTH];
  logic [AW-1:0] stack_mem [DEPTH];
  logic          cell_we, cell_re, stack_we, stack_re;
  logic [AW-1:0] cell_waddr, cell_raddr, stack_waddr, stack_raddr;
  logic [4:0]    cell_wdata, cell_rdata;
  logic [AW-1:0] stack_wdata, stack_rdata;

  // walk state
  logic [CFG_W-1:0] used_rows, used_cols;
  logic [CNT_W-1:0] total, count;
  logic [SW-1:0]    depth;
  logic [XW-1:0]    cur_x, nb_x, next_x;
  logic [YW-1:0]    cur_y, nb_y, next_y;
  logic [AW-1:0]    sweep_cnt;
  logic             scan_q, popped, has_nb;
  logic [2:0]       scan_sel_q;
  logic [3:0]       cur_walls, nb_vis, nb_w;
  logic [3:0]       nb_walls [4];
  logic [1:0]       dir;
  logic [7:0]       rand_q;
  logic [4:0]       qx_q, qy_q;

  // neighbor choice
  logic       up_ok, dn_ok, lf_ok, rt_ok;
  logic [3:0] open;
  logic [2:0] n_open;
  logic [10:0] prod;
  logic [1:0] pick_idx, pick_dir, seen;
  logic [AW-1:0] scan_addr, qaddr;
  logic [XW+4:0] qx_ext, cx_ext;
  logic [YW+4:0] qy_ext, cy_ext;
  logic          q_in_range;

  assign up_ok  = (9'(cur_y) + 9'd1) < 9'(used_cols);
  assign dn_ok  = (cur_y != '0);
  assign lf_ok  = (cur_x != '0);
  assign rt_ok  = (9'(cur_x) + 9'd1) < 9'(used_rows);
  assign open   = {rt_ok & ~nb_vis[3], lf_ok & ~nb_vis[2],
                   dn_ok & ~nb_vis[1], up_ok & ~nb_vis[0]};
  assign n_open = 3'($countones(open));
  assign prod   = 11'(rand_q) * 11'(n_open);
  assign pick_idx = prod[9:8];

  always_comb begin
    pick_dir = 2'd0;
    seen     = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (open[d]) begin
        if (seen == pick_idx) pick_dir = 2'(d);
        seen = seen + 2'd1;
      end
    end
  end

  always_comb begin
    next_x = cur_x;
    next_y = cur_y;
    unique case (pick_dir)
      2'd0: next_y = cur_y + YW'(1);
      2'd1: next_y = cur_y - YW'(1);
      2'd2: next_x = cur_x - XW'(1);
      2'd3: next_x = cur_x + XW'(1);
      default: next_x = cur_x;
    endcase
  end

  always_comb begin
    unique case (cmd.scan_sel)
      SCAN_UP:    scan_addr = {cur_x, cur_y + YW'(1)};
      SCAN_DOWN:  scan_addr = {cur_x, cur_y - YW'(1)};
      SCAN_LEFT:  scan_addr = {cur_x - XW'(1), cur_y};
      SCAN_RIGHT: scan_addr = {cur_x + XW'(1), cur_y};
      default:    scan_addr = {cur_x, cur_y};
    endcase
  end

  assign qx_ext     = {{XW{1'b0}}, qx_q};
  assign qy_ext     = {{YW{1'b0}}, qy_q};
  assign qaddr      = {qx_ext[XW-1:0], qy_ext[YW-1:0]};
  assign cx_ext     = {5'b00000, cur_x};
  assign cy_ext     = {5'b00000, cur_y};
  assign q_in_range = (9'(qx_q) < ROWS_LIM) && (9'(qy_q) < COLS_LIM);

  // memory port muxing
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = {cur_x, cur_y};
    cell_wdata = {1'b1, cur_walls & ~(4'b0001 << dir)};
    priority if (cmd.sweep) begin
      cell_we    = 1'b1;
      cell_waddr = sweep_cnt;
      cell_wdata = {sweep_cnt == '0, 4'hF};
    end else if (cmd.wr_cur) begin
      cell_we = 1'b1;
    end else if (cmd.wr_nb) begin
      cell_we    = 1'b1;
      cell_waddr = {nb_x, nb_y};
      cell_wdata = {1'b1, nb_w & ~(4'b0001 << (dir ^ 2'd1))};
    end
  end

  assign cell_re     = cmd.scan_rd | cmd.query_rd;
  assign cell_raddr  = cmd.query_rd ? qaddr : scan_addr;

  assign stack_we    = cmd.sweep | (cmd.wr_cur & (depth < CELLS));
  assign stack_waddr = cmd.sweep ? sweep_cnt : depth[AW-1:0];
  assign stack_wdata = cmd.sweep ? '0 : {nb_x, nb_y};
  assign stack_re    = cmd.pop_rd & (depth > SW'(1));
  assign stack_raddr = AW'(depth - SW'(2));

  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_waddr] <= cell_wdata;
    if (cell_re) cell_rdata <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (stack_re) stack_rdata <= stack_mem[stack_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used_rows <= clamp_size(CFG_RESET, ROWS_LIM);
      used_cols <= clamp_size(CFG_RESET, COLS_LIM);
      count     <= CNT_W'(1);
      depth     <= SW'(1);
      cur_x     <= '0;
      cur_y     <= '0;
      sweep_cnt <= '0;
      scan_q    <= 1'b0;
      popped    <= 1'b0;
      has_nb    <= 1'b0;
    end else begin
      scan_q <= cmd.scan_rd;
      if (cmd.init) begin
        used_rows <= clamp_size(grid_rows, ROWS_LIM);
        used_cols <= clamp_size(grid_cols, COLS_LIM);
        count     <= CNT_W'(1);
        depth     <= SW'(1);
        cur_x     <= '0;
        cur_y     <= '0;
      end
      if (cmd.sweep) sweep_cnt <= sweep_cnt + AW'(1);
      if (cmd.decide) has_nb <= (open != 4'b0000);
      if (stack_we && !cmd.sweep) depth <= depth + SW'(1);
      if (cmd.wr_nb) begin
        count <= count + CNT_W'(1);
        cur_x <= nb_x;
        cur_y <= nb_y;
      end
      if (cmd.pop_rd) begin
        popped <= stack_re;
        if (stack_re) depth <= depth - SW'(1);
      end
      if (cmd.pop_ld && popped) begin
        cur_x <= stack_rdata[AW-1:YW];
        cur_y <= stack_rdata[YW-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    total      <= CNT_W'(used_rows) * CNT_W'(used_cols);
    scan_sel_q <= cmd.scan_sel;
    if (cmd.latch) begin
      rand_q <= rand_value;
      qx_q   <= query_x;
      qy_q   <= query_y;
    end
    if (scan_q) begin
      unique case (scan_sel_q)
        SCAN_UP:    {nb_vis[0], nb_walls[0]} <= cell_rdata;
        SCAN_DOWN:  {nb_vis[1], nb_walls[1]} <= cell_rdata;
        SCAN_LEFT:  {nb_vis[2], nb_walls[2]} <= cell_rdata;
        SCAN_RIGHT: {nb_vis[3], nb_walls[3]} <= cell_rdata;
        default:    cur_walls <= cell_rdata[3:0];
      endcase
    end
    if (cmd.decide) begin
      dir  <= pick_dir;
      nb_x <= next_x;
      nb_y <= next_y;
      nb_w <= nb_walls[pick_dir];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      action    <= cmd.act;
      carve_dir <= (cmd.act == ACT_CARVED) ? dir : 2'd0;
      complete  <= (count >= total);
      if (cmd.act == ACT_READ) begin
        cell_x <= qx_q;
        cell_y <= qy_q;
        {wall_right, wall_left, wall_down, wall_up} <=
          q_in_range ? cell_rdata[3:0] : 4'hF;
      end else begin
        cell_x <= cx_ext[4:0];
        cell_y <= cy_ext[4:0];
        {wall_right, wall_left, wall_down, wall_up} <= 4'h0;
      end
    end
  end

  assign stat.complete   = (count >= total);
  assign stat.has_nb     = has_nb;
  assign stat.sweep_last = (sweep_cnt == {AW{1'b1}});
  assign stat.out_busy   = out_valid & ~out_ready;

endmodule

`default_nettype wire

/* sv/random_dfs_maze_carver.sv */
// Randomized depth-first maze carver, top level: configuration registers,
// controller and datapath. Depends on rdmc_pkg, rdmc_ctrl and rdmc_dpath.
//
// Input channel (in_valid/in_ready) takes one beat per operation: func 0
// starts a new maze, 1 carves one step, 2 or 3 reads one cell's walls
// (query_x, query_y). The output channel (out_valid/out_ready) returns one
// beat per operation, in order. One operation is in flight at a time.
// Each operation runs through the controller's state sequence over the
// cell memory's single read port:
//   read: one query read, then the result; step on a finished maze: the
//   result directly; carve or backtrack: five serial cell reads for the
//   current cell and its four neighbors, then decide and write back
//   (carve) or pop the path stack (backtrack). start: one clearing pass
//   over all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells, then the result.
// Reset runs the same clearing pass with in_ready low, and sets the grid to
// 32 by 32 with the walk at cell (0,0). The output register holds a result
// while out_ready is low; the next beat is still accepted and processed,
// and its result waits in the controller until the register frees.
// grid_rows and grid_cols (APB at 0x0 and 0x4) take effect at the next start.
`default_nettype none

module random_dfs_maze_carver import rdmc_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  rand_value,
  input  wire logic [4:0]  query_x,
  input  wire logic [4:0]  query_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       action,
  output logic [1:0]       carve_dir,
  output logic [4:0]       cell_x,
  output logic [4:0]       cell_y,
  output logic             wall_up,
  output logic             wall_down,
  output logic             wall_left,
  output logic             wall_right,
  output logic             complete
);

  logic [CFG_W-1:0] grid_rows, grid_cols;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_RESET;
      grid_cols <= CFG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) grid_cols <= pwdata[CFG_W-1:0];
      else          grid_rows <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = paddr[2] ? {{(32-CFG_W){1'b0}}, grid_cols}
                           : {{(32-CFG_W){1'b0}}, grid_rows};

  rdmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rdmc_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .grid_rows  (grid_rows),
    .grid_cols  (grid_cols),
    .rand_value (rand_value),
    .query_x    (query_x),
    .query_y    (query_y),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .action     (action),
    .carve_dir  (carve_dir),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .wall_up    (wall_up),
    .wall_down  (wall_down),
    .wall_left  (wall_left),
    .wall_right (wall_right),
    .complete   (complete)
  );

  // no beat is taken while the clearing pass runs
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> !in_ready)
    else $error("input accepted during clearing pass");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("output register overwritten");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("out_valid rose without a load");

  a_start_sweeps: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == FUNC_START) |=> cmd.sweep)
    else $error("start did not begin clearing pass");

endmodule

`default_nettype wire
